/* hw/rtl/qrs_pkg.sv */
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared result-kind codes for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

	localparam logic [2:0] KIND_TWO_REAL  = 3'd0;
	localparam logic [2:0] KIND_DOUBLE    = 3'd1;
	localparam logic [2:0] KIND_NONE_REAL = 3'd2;
	localparam logic [2:0] KIND_LINEAR    = 3'd3;
	localparam logic [2:0] KIND_NO_SOL    = 3'd4;
	localparam logic [2:0] KIND_INFINITE  = 3'd5;

endpackage

/* hw/rtl/qrs_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One digit step of a restoring square root; resolves one root bit per cell.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell #(
	parameter int R  = 33,
	parameter int PW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_i,
	input  logic [PW-1:0]   pay_i,
	input  logic [2*R-1:0]  rad_i,
	input  logic [R:0]      rem_i,
	input  logic [R-1:0]    root_i,
	output logic            vld_o,
	output logic [PW-1:0]   pay_o,
	output logic [2*R-1:0]  rad_o,
	output logic [R:0]      rem_o,
	output logic [R-1:0]    root_o
);

	logic [R+1:0] rem_sh;
	logic [R+1:0] trial;
	logic [R+1:0] diff;
	logic         ge;

	always_comb begin
		rem_sh = {rem_i[R-1:0], rad_i[2*R-1:2*R-2]};
		trial  = {root_i, 2'b01};
		ge     = rem_sh >= trial;
		diff   = rem_sh - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_o  <= pay_i;
			rad_o  <= {rad_i[2*R-3:0], 2'b00};
			rem_o  <= ge ? diff[R:0] : rem_sh[R:0];
			root_o <= {root_i[R-2:0], ge};
		end
	end

endmodule

/* hw/rtl/qrs_div_cell.sv */
// ----------------------------------------------------------------------------
// qrs_div_cell
// One step of a restoring divider; resolves one quotient bit per cell.
// ----------------------------------------------------------------------------
module qrs_div_cell #(
	parameter int NW = 50,
	parameter int DW = 33,
	parameter int PW = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_i,
	input  logic [PW-1:0]   pay_i,
	input  logic [NW-1:0]   num_i,
	input  logic [DW-1:0]   den_i,
	input  logic [DW-1:0]   rem_i,
	input  logic [NW-1:0]   quo_i,
	output logic            vld_o,
	output logic [PW-1:0]   pay_o,
	output logic [NW-1:0]   num_o,
	output logic [DW-1:0]   den_o,
	output logic [DW-1:0]   rem_o,
	output logic [NW-1:0]   quo_o
);

	logic [DW:0] rem_sh;
	logic [DW:0] diff;
	logic        ge;

	always_comb begin
		rem_sh = {rem_i, num_i[NW-1]};
		ge     = rem_sh >= {1'b0, den_i};
		diff   = rem_sh - {1'b0, den_i};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_o <= pay_i;
			num_o <= {num_i[NW-2:0], 1'b0};
			den_o <= den_i;
			rem_o <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
			quo_o <= {quo_i[NW-2:0], ge};
		end
	end

endmodule

/* hw/rtl/quadratic_root_solver_top.sv */
// ----------------------------------------------------------------------------
// quadratic_root_solver_top
// Classifies and solves a*x^2 + b*x + c = 0 on signed fixed-point inputs.
// ----------------------------------------------------------------------------
// Takes one request (coef_a, coef_b, coef_c) per cycle while the pipe
// advances and returns one result per request, in order. A request passes
// the magnitude, product and discriminant stages, a square-root chain of
// COEF_WIDTH+1 cells, the numerator stage, two parallel divider chains
// of COEF_WIDTH+FRAC_BITS+2 cells, one bit per cell, then the output
// register. The whole pipe advances whenever the output register is empty
// or being taken, so a stalled consumer freezes every stage in place. The
// discriminant is exact; roots are rounded to nearest (ties away from zero)
// and clipped to the signed COEF_WIDTH range, with saturated set on a clip.
// ----------------------------------------------------------------------------
module quadratic_root_solver_top #(
	parameter int FRAC_BITS  = 16,
	parameter int COEF_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COEF_WIDTH-1:0] coef_a,
	input  logic signed [COEF_WIDTH-1:0] coef_b,
	input  logic signed [COEF_WIDTH-1:0] coef_c,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COEF_WIDTH-1:0] root_first,
	output logic signed [COEF_WIDTH-1:0] root_second,
	output logic [2:0]                   root_kind,
	output logic                         saturated
);

	localparam int W  = COEF_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int R  = W + 1;          // square root bits
	localparam int NW = W + 2 + F;      // numerator / quotient bits
	localparam int DW = W + 1;          // divisor bits

	// side data riding along the square-root chain
	typedef struct packed {
		logic [2:0]   kind;
		logic         aneg;
		logic [W-1:0] am;
		logic         bneg;
		logic [W-1:0] bm;
		logic         cneg;
		logic [W-1:0] cm;
	} sq_pay_t;

	// side data riding along the divider chains
	typedef struct packed {
		logic [2:0] kind;
		logic       neg;
	} dv_pay_t;

	localparam int SPW = $bits(sq_pay_t);
	localparam int DPW = $bits(dv_pay_t);

	logic adv;
	logic out_valid_q;

	// the pipe moves as a whole when the output slot is free or being taken
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// ---------------- stage 1: magnitudes and signs
	logic         vld_s1;
	logic [W-1:0] am_s1, bm_s1, cm_s1;
	logic         aneg_s1, bneg_s1, cneg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			aneg_s1 <= coef_a[W-1];
			bneg_s1 <= coef_b[W-1];
			cneg_s1 <= coef_c[W-1];
			am_s1   <= coef_a[W-1] ? W'(-coef_a) : W'(coef_a);
			bm_s1   <= coef_b[W-1] ? W'(-coef_b) : W'(coef_b);
			cm_s1   <= coef_c[W-1] ? W'(-coef_c) : W'(coef_c);
		end
	end

	// ---------------- stage 2: b*b and a*c
	logic           vld_s2;
	logic [2*W-1:0] bb_s2, ac_s2;
	logic [W-1:0]   am_s2, bm_s2, cm_s2;
	logic           aneg_s2, bneg_s2, cneg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bb_s2   <= bm_s1 * bm_s1;
			ac_s2   <= am_s1 * cm_s1;
			am_s2   <= am_s1;
			bm_s2   <= bm_s1;
			cm_s2   <= cm_s1;
			aneg_s2 <= aneg_s1;
			bneg_s2 <= bneg_s1;
			cneg_s2 <= cneg_s1;
		end
	end

	// ---------------- stage 3: discriminant and classification
	logic [2*R-1:0] bb_x, ac4_x, disc_x;
	logic           acneg_x, gt_x, eq_x;
	logic [2:0]     kind_x;
	logic           vld_s3;
	logic [2*R-1:0] disc_s3;
	sq_pay_t        pay_s3;

	always_comb begin
		bb_x    = {2'b00, bb_s2};
		ac4_x   = {ac_s2, 2'b00};
		acneg_x = (aneg_s2 != cneg_s2) && (cm_s2 != '0);
		if (acneg_x) begin
			disc_x = bb_x + ac4_x;
			gt_x   = 1'b1;
			eq_x   = 1'b0;
		end else begin
			gt_x   = bb_x > ac4_x;
			eq_x   = bb_x == ac4_x;
			disc_x = gt_x ? (bb_x - ac4_x) : bb_x;
		end
		if (am_s2 == '0) begin
			if (bm_s2 == '0) begin
				kind_x = (cm_s2 == '0) ? qrs_pkg::KIND_INFINITE : qrs_pkg::KIND_NO_SOL;
			end else begin
				kind_x = qrs_pkg::KIND_LINEAR;
			end
		end else if (gt_x) begin
			kind_x = qrs_pkg::KIND_TWO_REAL;
		end else if (eq_x) begin
			kind_x = qrs_pkg::KIND_DOUBLE;
		end else begin
			kind_x = qrs_pkg::KIND_NONE_REAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			disc_s3     <= disc_x;
			pay_s3.kind <= kind_x;
			pay_s3.aneg <= aneg_s2;
			pay_s3.am   <= am_s2;
			pay_s3.bneg <= bneg_s2;
			pay_s3.bm   <= bm_s2;
			pay_s3.cneg <= cneg_s2;
			pay_s3.cm   <= cm_s2;
		end
	end

	// ---------------- square-root chain
	logic           sq_vld  [0:R];
	logic [SPW-1:0] sq_pay  [0:R];
	logic [2*R-1:0] sq_rad  [0:R];
	logic [R:0]     sq_rem  [0:R];
	logic [R-1:0]   sq_root [0:R];

	assign sq_vld[0]  = vld_s3;
	assign sq_pay[0]  = pay_s3;
	assign sq_rad[0]  = disc_s3;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar gi = 0; gi < R; gi++) begin : g_sqrt
		qrs_sqrt_cell #(
			.R  (R),
			.PW (SPW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.vld_i  (sq_vld[gi]),
			.pay_i  (sq_pay[gi]),
			.rad_i  (sq_rad[gi]),
			.rem_i  (sq_rem[gi]),
			.root_i (sq_root[gi]),
			.vld_o  (sq_vld[gi+1]),
			.pay_o  (sq_pay[gi+1]),
			.rad_o  (sq_rad[gi+1]),
			.rem_o  (sq_rem[gi+1]),
			.root_o (sq_root[gi+1])
		);
	end

	// ---------------- numerator stage
	sq_pay_t        sp;
	logic [W+2:0]   negb_x, s_x, n1_x, n2_x;
	logic [W+1:0]   nm1_x, nm2_x;
	logic [NW-1:0]  num1_x, num2_x;
	logic [DW-1:0]  den_x;
	logic           neg1_x, neg2_x;
	logic           vld_s4;
	logic [NW-1:0]  num1_s4, num2_s4;
	logic [DW-1:0]  den_s4;
	dv_pay_t        pay1_s4, pay2_s4;

	always_comb begin
		sp     = sq_pay[R];
		negb_x = sp.bneg ? {3'b000, sp.bm} : (W+3)'(-{3'b000, sp.bm});
		// a double root uses -b alone
		s_x    = (sp.kind == qrs_pkg::KIND_TWO_REAL) ? {2'b00, sq_root[R]} : '0;
		n1_x   = negb_x + s_x;
		n2_x   = negb_x - s_x;
		nm1_x  = n1_x[W+2] ? (W+2)'(-n1_x) : n1_x[W+1:0];
		nm2_x  = n2_x[W+2] ? (W+2)'(-n2_x) : n2_x[W+1:0];
		if (sp.kind == qrs_pkg::KIND_LINEAR) begin
			num1_x = {2'b00, sp.cm, {F{1'b0}}};
			den_x  = {1'b0, sp.bm};
			neg1_x = (sp.cm != '0) && (sp.cneg == sp.bneg);
		end else begin
			num1_x = {nm1_x, {F{1'b0}}};
			den_x  = {sp.am, 1'b0};
			neg1_x = n1_x[W+2] != sp.aneg;
		end
		num2_x = {nm2_x, {F{1'b0}}};
		neg2_x = n2_x[W+2] != sp.aneg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= sq_vld[R];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num1_s4      <= num1_x;
			num2_s4      <= num2_x;
			den_s4       <= den_x;
			pay1_s4.kind <= sp.kind;
			pay1_s4.neg  <= neg1_x;
			pay2_s4.kind <= sp.kind;
			pay2_s4.neg  <= neg2_x;
		end
	end

	// ---------------- divider chains, plus and minus branch
	logic           d1_vld [0:NW];
	logic [DPW-1:0] d1_pay [0:NW];
	logic [NW-1:0]  d1_num [0:NW];
	logic [DW-1:0]  d1_den [0:NW];
	logic [DW-1:0]  d1_rem [0:NW];
	logic [NW-1:0]  d1_quo [0:NW];
	logic           d2_vld [0:NW];
	logic [DPW-1:0] d2_pay [0:NW];
	logic [NW-1:0]  d2_num [0:NW];
	logic [DW-1:0]  d2_den [0:NW];
	logic [DW-1:0]  d2_rem [0:NW];
	logic [NW-1:0]  d2_quo [0:NW];

	assign d1_vld[0] = vld_s4;
	assign d1_pay[0] = pay1_s4;
	assign d1_num[0] = num1_s4;
	assign d1_den[0] = den_s4;
	assign d1_rem[0] = '0;
	assign d1_quo[0] = '0;
	assign d2_vld[0] = vld_s4;
	assign d2_pay[0] = pay2_s4;
	assign d2_num[0] = num2_s4;
	assign d2_den[0] = den_s4;
	assign d2_rem[0] = '0;
	assign d2_quo[0] = '0;

	for (genvar gj = 0; gj < NW; gj++) begin : g_div
		qrs_div_cell #(
			.NW (NW),
			.DW (DW),
			.PW (DPW)
		) u_plus (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.vld_i  (d1_vld[gj]),
			.pay_i  (d1_pay[gj]),
			.num_i  (d1_num[gj]),
			.den_i  (d1_den[gj]),
			.rem_i  (d1_rem[gj]),
			.quo_i  (d1_quo[gj]),
			.vld_o  (d1_vld[gj+1]),
			.pay_o  (d1_pay[gj+1]),
			.num_o  (d1_num[gj+1]),
			.den_o  (d1_den[gj+1]),
			.rem_o  (d1_rem[gj+1]),
			.quo_o  (d1_quo[gj+1])
		);

		qrs_div_cell #(
			.NW (NW),
			.DW (DW),
			.PW (DPW)
		) u_minus (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.vld_i  (d2_vld[gj]),
			.pay_i  (d2_pay[gj]),
			.num_i  (d2_num[gj]),
			.den_i  (d2_den[gj]),
			.rem_i  (d2_rem[gj]),
			.quo_i  (d2_quo[gj]),
			.vld_o  (d2_vld[gj+1]),
			.pay_o  (d2_pay[gj+1]),
			.num_o  (d2_num[gj+1]),
			.den_o  (d2_den[gj+1]),
			.rem_o  (d2_rem[gj+1]),
			.quo_o  (d2_quo[gj+1])
		);
	end

	// ---------------- round, clip, sign, select
	dv_pay_t      p1, p2;
	logic [NW:0]  qr1, qr2, lim1, lim2;
	logic         sat1, sat2;
	logic [W-1:0] mag1, mag2, r1_x, r2_x;
	logic [W-1:0] first_x, second_x;
	logic         sat_x;

	always_comb begin
		p1   = d1_pay[NW];
		p2   = d2_pay[NW];
		qr1  = {1'b0, d1_quo[NW]} +
			(NW+1)'({d1_rem[NW], 1'b0} >= {1'b0, d1_den[NW]});
		qr2  = {1'b0, d2_quo[NW]} +
			(NW+1)'({d2_rem[NW], 1'b0} >= {1'b0, d2_den[NW]});
		lim1 = (NW+1)'(1) << (W - 1);
		lim2 = lim1;
		if (!p1.neg) begin
			lim1 = lim1 - (NW+1)'(1);
		end
		if (!p2.neg) begin
			lim2 = lim2 - (NW+1)'(1);
		end
		sat1 = qr1 > lim1;
		sat2 = qr2 > lim2;
		mag1 = sat1 ? lim1[W-1:0] : qr1[W-1:0];
		mag2 = sat2 ? lim2[W-1:0] : qr2[W-1:0];
		r1_x = p1.neg ? W'(-mag1) : mag1;
		r2_x = p2.neg ? W'(-mag2) : mag2;
		case (p1.kind)
			qrs_pkg::KIND_TWO_REAL: begin
				first_x  = r1_x;
				second_x = r2_x;
				sat_x    = sat1 || sat2;
			end
			qrs_pkg::KIND_DOUBLE, qrs_pkg::KIND_LINEAR: begin
				first_x  = r1_x;
				second_x = r1_x;
				sat_x    = sat1;
			end
			default: begin
				first_x  = '0;
				second_x = '0;
				sat_x    = 1'b0;
			end
		endcase
	end

	// ---------------- output register
	logic [W-1:0] first_q, second_q;
	logic [2:0]   kind_q;
	logic         sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= d1_vld[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			first_q  <= first_x;
			second_q <= second_x;
			kind_q   <= p1.kind;
			sat_q    <= sat_x;
		end
	end

	assign out_valid   = out_valid_q;
	assign root_first  = first_q;
	assign root_second = second_q;
	assign root_kind   = kind_q;
	assign saturated   = sat_q;

endmodule

/* bench/quadratic_root_solver_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_top_tb
// Self-checking bench for the quadratic root solver.
// ----------------------------------------------------------------------------
// Every request gets its expected result from a predictor in the bench:
// exact discriminant, floor square root, rounded and clipped quotient.
// The directed tests hit each kind of equation, the field extremes and
// root clipping. The random test mixes full-range, short-magnitude,
// linear and built double-root requests. Both sides of the handshake
// idle at random, except in one quiet stretch. Results are checked field
// by field, in order.
// ----------------------------------------------------------------------------
module quadratic_root_solver_top_tb;

	localparam int FRAC_BITS  = 16;
	localparam int COEF_WIDTH = 32;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct packed {
		logic [31:0] root_first;
		logic [31:0] root_second;
		logic [2:0]  root_kind;
		logic        saturated;
	} roots_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] coef_a;
	logic [31:0] coef_b;
	logic [31:0] coef_c;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] root_first;
	logic [31:0] root_second;
	logic [2:0]  root_kind;
	logic        saturated;

	roots_t pending_roots[$];
	int     error_count;
	int     stall_cycles;
	bit     quiet;	// when set, neither side idles

	quadratic_root_solver_top #(
		.FRAC_BITS (FRAC_BITS),
		.COEF_WIDTH(COEF_WIDTH)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.coef_a     (coef_a),
		.coef_b     (coef_b),
		.coef_c     (coef_c),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.root_first (root_first),
		.root_second(root_second),
		.root_kind  (root_kind),
		.saturated  (saturated)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// ---------------------------------------------------------------- predictor

	// Rounded (ties away from zero) num/den, clipped to 32-bit signed.
	// Returns {clipped, value}.
	function automatic logic [32:0] rounded_quotient(bit neg, logic [127:0] num,
			logic [127:0] den);
		logic [127:0] q;
		logic [127:0] r;
		logic [127:0] lim;
		bit           clip;
		q = num / den;
		r = num % den;
		if ((r << 1) >= den) q = q + 1;
		lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
		clip = 1'b0;
		if (q > lim) begin
			clip = 1'b1;
			q = lim;
		end
		if (neg) q = -q;
		return {clip, q[31:0]};
	endfunction

	// n / (2a), scaled so the result carries FRAC_BITS fraction bits
	function automatic logic [32:0] root_over_2a(logic signed [63:0] n, logic [63:0] am,
			bit aneg);
		bit          nneg;
		logic [63:0] nm;
		nneg = n < 0;
		nm = nneg ? -n : n;
		return rounded_quotient(nneg != aneg, {64'd0, nm} << FRAC_BITS,
			{64'd0, am} << 1);
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [127:0] v);
		logic [63:0] res;
		logic [63:0] cand;
		res = '0;
		for (int i = 63; i >= 0; i--) begin
			cand = res | (64'd1 << i);
			if ({64'd0, cand} * {64'd0, cand} <= v) res = cand;
		end
		return res;
	endfunction

	function automatic roots_t solve_quadratic(logic [31:0] a, logic [31:0] b,
			logic [31:0] c);
		roots_t            res;
		logic signed [63:0] av, bv, cv, s;
		logic [63:0]       am, bm, cm;
		logic [127:0]      b2, ac4, disc;
		logic [32:0]       r1, r2;
		bit                acneg;
		int                cmpv;
		av = $signed(a);
		bv = $signed(b);
		cv = $signed(c);
		am = av < 0 ? -av : av;
		bm = bv < 0 ? -bv : bv;
		cm = cv < 0 ? -cv : cv;
		r1 = '0;
		r2 = '0;
		if (am == 0) begin
			if (bm == 0) begin
				res.root_kind = (cm == 0) ? qrs_pkg::KIND_INFINITE : qrs_pkg::KIND_NO_SOL;
			end else begin
				res.root_kind = qrs_pkg::KIND_LINEAR;
				r1 = rounded_quotient(cm != 0 && (cv < 0) == (bv < 0),
					{64'd0, cm} << FRAC_BITS, {64'd0, bm});
				r2 = r1;
			end
		end else begin
			b2 = {64'd0, bm} * {64'd0, bm};
			ac4 = ({64'd0, am} * {64'd0, cm}) << 2;
			acneg = ((av < 0) != (cv < 0)) && cm != 0;
			if (acneg) begin
				disc = b2 + ac4;
				cmpv = 1;
			end else begin
				cmpv = (b2 > ac4) ? 1 : (b2 == ac4) ? 0 : -1;
				disc = b2 - ac4;
			end
			if (cmpv < 0) begin
				res.root_kind = qrs_pkg::KIND_NONE_REAL;
			end else if (cmpv == 0) begin
				res.root_kind = qrs_pkg::KIND_DOUBLE;
				r1 = root_over_2a(-bv, am, av < 0);
				r2 = r1;
			end else begin
				res.root_kind = qrs_pkg::KIND_TWO_REAL;
				s = floor_sqrt(disc);
				r1 = root_over_2a(-bv + s, am, av < 0);
				r2 = root_over_2a(-bv - s, am, av < 0);
			end
		end
		res.root_first  = r1[31:0];
		res.root_second = r2[31:0];
		res.saturated   = r1[32] | r2[32];
		return res;
	endfunction

	// ---------------------------------------------------------------- driving

	task automatic send_request(logic [31:0] a, logic [31:0] b, logic [31:0] c);
		while (!quiet && $urandom_range(0, 99) < 30) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		coef_a   <= a;
		coef_b   <= b;
		coef_c   <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_roots.push_back(solve_quadratic(a, b, c));
	endtask

	// mostly short magnitudes, either sign
	function automatic logic [31:0] random_coef();
		logic [31:0] v;
		v = $urandom >> $urandom_range(0, 31);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	// ---------------------------------------------------------------- checking

	always @(posedge clk) begin
		roots_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_roots.size() == 0) begin
				$error("result with no request outstanding");
				error_count++;
			end else begin
				want = pending_roots.pop_front();
				if (root_first !== want.root_first) begin
					$error("root_first: expected %h, got %h", want.root_first, root_first);
					error_count++;
				end
				if (root_second !== want.root_second) begin
					$error("root_second: expected %h, got %h", want.root_second,
						root_second);
					error_count++;
				end
				if (root_kind !== want.root_kind) begin
					$error("root_kind: expected %0d, got %0d", want.root_kind, root_kind);
					error_count++;
				end
				if (saturated !== want.saturated) begin
					$error("saturated: expected %b, got %b", want.saturated, saturated);
					error_count++;
				end
			end
		end
		out_ready <= quiet || $urandom_range(0, 99) >= 30;
	end

	// watchdog: cycles in which neither side moves a request or result
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests

	// at least one request per kind of equation
	task automatic test_each_kind();
		send_request(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000);	// x^2-3x+2
		send_request(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000);	// double at 1
		send_request(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);	// no real root
		send_request(32'h0000_0000, 32'h0002_0000, 32'hFFFF_0000);	// linear
		send_request(32'h0000_0000, 32'h0000_0000, 32'h0005_0000);	// no solution
		send_request(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);	// infinitely many
		send_request(32'hFFFF_0000, 32'h0000_0000, 32'h0004_0000);	// negative a
		send_request(32'h0003_0000, 32'h0000_0000, 32'h0000_0000);	// zero c, zero b
	endtask

	// extreme field values and clipped roots
	task automatic test_extremes();
		send_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_request(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000);	// huge roots
		send_request(32'h0000_0001, 32'h8000_0000, 32'h0000_0000);
		send_request(32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF);	// linear, clipped -
		send_request(32'h0000_0000, 32'h0000_0001, 32'h8000_0000);	// linear, clipped +
		send_request(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);	// linear, zero root
		send_request(32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
		send_request(32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0001);
		send_request(32'hFFFF_FFFF, 32'h0000_0002, 32'hFFFF_FFFF);	// double, tiny a
		send_request(32'h8000_0000, 32'h0000_0000, 32'h0000_0000);	// double at 0
	endtask

	task automatic test_random(int count);
		logic [31:0] a, b, c;
		logic signed [31:0] r;
		for (int n = 0; n < count; n++) begin
			quiet = (n >= count / 3 && n < count / 3 + 300);
			case ($urandom_range(0, 9))
				0: begin
					a = '0;
					b = $urandom_range(0, 3) == 0 ? '0 : random_coef();
					c = random_coef();
				end
				1: begin
					// double root at integer r: b = -2ar, c = ar^2
					a = random_coef() >> $urandom_range(8, 20);
					if (a == 0) a = 32'h0001_0000;
					r = $signed($urandom_range(0, 15)) - 8;
					b = -2 * $signed(a) * r;
					c = $signed(a) * r * r;
				end
				2, 3, 4: begin
					a = $urandom;
					b = $urandom;
					c = $urandom;
				end
				default: begin
					a = random_coef();
					b = random_coef();
					c = random_coef();
				end
			endcase
			send_request(a, b, c);
		end
		quiet = 1'b0;
	endtask

	initial begin
		error_count  = 0;
		stall_cycles = 0;
		quiet        = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		out_ready    = 1'b0;
		coef_a       = '0;
		coef_b       = '0;
		coef_c       = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_each_kind();
		test_extremes();
		test_random(1500);

		in_valid <= 1'b0;
		while (pending_roots.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/qrs_pkg.sv
hw/rtl/qrs_sqrt_cell.sv
hw/rtl/qrs_div_cell.sv
hw/rtl/quadratic_root_solver_top.sv
bench/quadratic_root_solver_top_tb.sv
